// ===== hw/rtl/bat_pkg.sv =====
package bat_pkg;

  // Per-node state codes held in the node memory.
  typedef enum logic [1:0] {
    NS_ABSENT = 2'd0,
    NS_FREE   = 2'd1,
    NS_ALLOC  = 2'd2,
    NS_SPLIT  = 2'd3
  } node_st_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_STRAY    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_INIT,
    S_A_POP,
    S_A_EVAL,
    S_A_SPL1,
    S_A_SPL2,
    S_A_FAIL,
    S_A_GROW,
    S_F_RD,
    S_F_EV,
    S_F_C,
    S_F_O,
    S_F_M1,
    S_F_M2
  } fsm_t;

  localparam int ADDR_W     = 12;
  localparam int SIZE_W     = 13;
  localparam int ORD_W      = 4;
  localparam int K_W        = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_INIT_ORDER = 2'd0;
  localparam logic [ORD_W-1:0]      INIT_ORDER_RST = 4'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

// ===== hw/rtl/buddy_allocator_tree_top.sv =====
// Buddy allocator over a heap that can double in size.
// Input channel: a transaction is taken at a rising edge with start high
// and busy low. in_operation selects allocate or free; in_request_size is
// the byte count for an allocate and in_block_address the block base for
// a free. Each transaction not cut short by a write to the initial order
// register yields exactly one result, shown for a single cycle with
// out_valid high: out_result_address, out_status and out_heap_order.
// The receiver cannot stall, so results are never held. Latency depends on
// the tree walk: each allocate node visit reads the node memory and then
// evaluates the node, a split free leaf has both children written free,
// and each heap doubling writes a new split root and a free buddy for the
// old root, then repeats the search. A free reads the root, reads one child
// per tree level it descends, then releases the block and may merge it with
// its free buddy. The node memory has a registered read; busy stays high
// until the result is shown, so the block handles one transaction at a time.
// After reset, and after every write to the initial order register, the
// node memory is swept entry by entry over all 2^(MAX_ORDER+1) entries
// (8192 with the defaults), with busy high. The sweep leaves the root a
// free leaf at the saturated initial order and all other nodes absent.
module buddy_allocator_tree_top #(
  parameter int MAX_HEAP  = 4096,
  parameter int MAX_ORDER = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_operation,
  input  logic [bat_pkg::SIZE_W-1:0]        in_request_size,
  input  logic [bat_pkg::ADDR_W-1:0]        in_block_address,
  output logic                              out_valid,
  output logic [bat_pkg::ADDR_W-1:0]        out_result_address,
  output logic [1:0]                        out_status,
  output logic [bat_pkg::ORD_W-1:0]         out_heap_order,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bat_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bat_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bat_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int NW     = MAX_ORDER + 1;
  localparam int DEPTH  = 1 << NW;
  localparam int STACK  = MAX_ORDER + 1;
  localparam int SPW    = $clog2(STACK + 1);
  localparam int IW     = $clog2(STACK);
  localparam int FLOG   = $clog2(MAX_HEAP + 1) - 1;
  // Largest heap order that fits both the tree and the byte limit.
  localparam int LIM    = (FLOG < MAX_ORDER) ? FLOG : MAX_ORDER;
  localparam int OW     = bat_pkg::ORD_W;
  localparam int KW     = bat_pkg::K_W;

  bat_pkg::fsm_t state_r, state_nxt;

  logic [OW-1:0]      init_r, init_nxt;
  logic [OW-1:0]      cho_r, cho_nxt;
  logic [NW-1:0]      clr_r, clr_nxt;
  logic [NW-1:0]      i_r, i_nxt;
  logic [NW-1:0]      c_r, c_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [bat_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [SPW-1:0]     sp_r, sp_nxt;
  logic [NW-1:0]      stack_r [STACK];

  logic               out_valid_r, out_valid_nxt;
  logic [bat_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [OW-1:0]      out_ord_r, out_ord_nxt;

  // Node memory port.
  logic               ram_we, ram_re;
  logic [NW-1:0]      ram_waddr, ram_raddr;
  bat_pkg::node_st_t  ram_wdata;
  logic [1:0]         ram_rdata;
  bat_pkg::node_st_t  rd_st;

  // Stack pushes.
  logic               push;
  logic [SPW-1:0]     sp_m1;
  logic [NW-1:0]      top_idx;

  // Decoded node geometry.
  logic [OW-1:0]        ord_a, ord_b;
  logic [MAX_ORDER-1:0] base_a, base_b;
  logic [NW-1:0]        idx_b;
  logic [NW-1:0]        left_idx, right_idx, root_idx, clr_root;
  logic [OW-1:0]        cfg_sat;

  logic               cfg_wr;
  logic               accept;
  logic [KW-1:0]      k_in;
  logic [bat_pkg::SIZE_W-1:0] size_m1;

  // Evaluation decode.
  logic               ev_skip, ev_exact, ev_hit, ev_split;
  logic               fe_match, fe_stop, fe_go_right;
  logic               fin;
  logic [bat_pkg::ADDR_W-1:0] fin_addr;
  logic [1:0]         fin_status;

  bat_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bat_node #(.MAX_ORDER(MAX_ORDER)) u_node_a (
    .idx   (i_r),
    .order (ord_a),
    .base  (base_a)
  );

  bat_node #(.MAX_ORDER(MAX_ORDER)) u_node_b (
    .idx   (idx_b),
    .order (ord_b),
    .base  (base_b)
  );

  assign rd_st     = bat_pkg::node_st_t'(ram_rdata);
  assign left_idx  = {i_r[NW-2:0], 1'b0};
  assign right_idx = {i_r[NW-2:0], 1'b1};
  assign idx_b     = (state_r == bat_pkg::S_F_C) ? c_r : right_idx;
  assign root_idx  = NW'(1) << (OW'(MAX_ORDER) - cho_r);
  assign clr_root  = root_idx;

  assign cfg_wr  = psel && penable && pwrite && (paddr == bat_pkg::REG_INIT_ORDER);
  assign cfg_sat = (pwdata[OW-1:0] > OW'(LIM)) ? OW'(LIM) : pwdata[OW-1:0];
  assign pready  = 1'b1;
  assign prdata  = bat_pkg::CFG_DATA_W'(init_r);

  assign busy   = (state_r != bat_pkg::S_IDLE);
  assign accept = start && !busy;

  // Round the request up to a power of two: k is the bit length of size-1.
  assign size_m1 = in_request_size - bat_pkg::SIZE_W'(1);
  always_comb begin
    k_in = '0;
    if (in_request_size > bat_pkg::SIZE_W'(1)) begin
      for (int b = 0; b < bat_pkg::SIZE_W; b++) begin
        if (size_m1[b]) begin
          k_in = KW'(b + 1);
        end
      end
    end
    if (k_in > KW'(MAX_ORDER + 1)) begin
      k_in = KW'(MAX_ORDER + 1);
    end
  end

  assign sp_m1   = sp_r - SPW'(1);
  assign top_idx = stack_r[sp_m1[IW-1:0]];

  // Search step decode for the node just read.
  assign ev_skip  = (rd_st == bat_pkg::NS_ALLOC) || (rd_st == bat_pkg::NS_ABSENT) ||
                    ({1'b0, ord_a} < k_r);
  assign ev_exact = ({1'b0, ord_a} == k_r);
  assign ev_hit   = !ev_skip && ev_exact && (rd_st == bat_pkg::NS_FREE);
  assign ev_split = !ev_skip && !ev_exact && (rd_st == bat_pkg::NS_FREE);
  assign push     = (state_r == bat_pkg::S_A_EVAL) && !ev_skip && !ev_exact &&
                    ((KW'(sp_r) + KW'(2)) <= KW'(STACK));

  // Free step decode.
  assign fe_match    = (rd_st == bat_pkg::NS_ALLOC) &&
                       (16'(base_a) == 16'(addr_r));
  assign fe_stop     = (rd_st != bat_pkg::NS_SPLIT) || (ord_a == '0);
  assign fe_go_right = (16'(addr_r) >= 16'(base_b));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bat_pkg::S_CLEAR: begin
        if (clr_r == {NW{1'b1}}) state_nxt = bat_pkg::S_IDLE;
      end
      bat_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_operation == bat_pkg::OP_FREE) ? bat_pkg::S_F_RD
                                                         : bat_pkg::S_A_INIT;
        end
      end
      bat_pkg::S_A_INIT: state_nxt = bat_pkg::S_A_POP;
      bat_pkg::S_A_POP: begin
        state_nxt = (sp_r == '0) ? bat_pkg::S_A_FAIL : bat_pkg::S_A_EVAL;
      end
      bat_pkg::S_A_EVAL: begin
        if (ev_hit)        state_nxt = bat_pkg::S_IDLE;
        else if (ev_split) state_nxt = bat_pkg::S_A_SPL1;
        else               state_nxt = bat_pkg::S_A_POP;
      end
      bat_pkg::S_A_SPL1: state_nxt = bat_pkg::S_A_SPL2;
      bat_pkg::S_A_SPL2: state_nxt = bat_pkg::S_A_POP;
      bat_pkg::S_A_FAIL: begin
        state_nxt = (cho_r >= OW'(LIM)) ? bat_pkg::S_IDLE : bat_pkg::S_A_GROW;
      end
      bat_pkg::S_A_GROW: state_nxt = bat_pkg::S_A_INIT;
      bat_pkg::S_F_RD:   state_nxt = bat_pkg::S_F_EV;
      bat_pkg::S_F_EV: begin
        state_nxt = (fe_match || fe_stop) ? bat_pkg::S_IDLE : bat_pkg::S_F_C;
      end
      bat_pkg::S_F_C: begin
        state_nxt = (rd_st != bat_pkg::NS_ALLOC) ? bat_pkg::S_F_EV : bat_pkg::S_F_O;
      end
      bat_pkg::S_F_O: begin
        state_nxt = (rd_st == bat_pkg::NS_FREE) ? bat_pkg::S_F_M1 : bat_pkg::S_IDLE;
      end
      bat_pkg::S_F_M1: state_nxt = bat_pkg::S_F_M2;
      bat_pkg::S_F_M2: state_nxt = bat_pkg::S_IDLE;
      default:         state_nxt = bat_pkg::S_IDLE;
    endcase
    if (cfg_wr) state_nxt = bat_pkg::S_CLEAR;
  end

  // Datapath and memory controls.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = i_r;
    ram_wdata  = bat_pkg::NS_ABSENT;
    ram_re     = 1'b0;
    ram_raddr  = i_r;
    init_nxt   = init_r;
    cho_nxt    = cho_r;
    clr_nxt    = clr_r;
    i_nxt      = i_r;
    c_nxt      = c_r;
    k_nxt      = k_r;
    addr_nxt   = addr_r;
    st_nxt     = st_r;
    sp_nxt     = sp_r;
    fin        = 1'b0;
    fin_addr   = '0;
    fin_status = bat_pkg::ST_OK;
    case (state_r)
      bat_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = (clr_r == clr_root) ? bat_pkg::NS_FREE : bat_pkg::NS_ABSENT;
        clr_nxt   = clr_r + NW'(1);
      end
      bat_pkg::S_IDLE: begin
        if (accept) begin
          k_nxt    = k_in;
          addr_nxt = in_block_address;
          i_nxt    = root_idx;
        end
      end
      bat_pkg::S_A_INIT: begin
        sp_nxt = SPW'(1);
      end
      bat_pkg::S_A_POP: begin
        if (sp_r != '0) begin
          i_nxt     = top_idx;
          ram_re    = 1'b1;
          ram_raddr = top_idx;
          sp_nxt    = sp_m1;
        end
      end
      bat_pkg::S_A_EVAL: begin
        if (ev_hit) begin
          ram_we     = 1'b1;
          ram_wdata  = bat_pkg::NS_ALLOC;
          fin        = 1'b1;
          fin_addr   = bat_pkg::ADDR_W'(base_a);
        end else if (ev_split) begin
          ram_we    = 1'b1;
          ram_wdata = bat_pkg::NS_SPLIT;
        end
        if (push) sp_nxt = sp_r + SPW'(2);
      end
      bat_pkg::S_A_SPL1: begin
        ram_we    = 1'b1;
        ram_waddr = left_idx;
        ram_wdata = bat_pkg::NS_FREE;
      end
      bat_pkg::S_A_SPL2: begin
        ram_we    = 1'b1;
        ram_waddr = right_idx;
        ram_wdata = bat_pkg::NS_FREE;
      end
      bat_pkg::S_A_FAIL: begin
        if (cho_r >= OW'(LIM)) begin
          fin        = 1'b1;
          fin_status = bat_pkg::ST_OOM;
        end else begin
          // The parent of the old root becomes the new, split root.
          ram_we    = 1'b1;
          ram_waddr = root_idx >> 1;
          ram_wdata = bat_pkg::NS_SPLIT;
        end
      end
      bat_pkg::S_A_GROW: begin
        ram_we    = 1'b1;
        ram_waddr = root_idx + NW'(1);
        ram_wdata = bat_pkg::NS_FREE;
        cho_nxt   = cho_r + OW'(1);
      end
      bat_pkg::S_F_RD: begin
        ram_re = 1'b1;
      end
      bat_pkg::S_F_EV: begin
        if (fe_match) begin
          ram_we    = 1'b1;
          ram_wdata = bat_pkg::NS_FREE;
          fin       = 1'b1;
        end else if (fe_stop) begin
          fin        = 1'b1;
          fin_status = bat_pkg::ST_STRAY;
        end else begin
          c_nxt     = fe_go_right ? right_idx : left_idx;
          ram_re    = 1'b1;
          ram_raddr = fe_go_right ? right_idx : left_idx;
        end
      end
      bat_pkg::S_F_C: begin
        if (rd_st != bat_pkg::NS_ALLOC) begin
          // The state of c is still on the read port; walk on from it.
          i_nxt = c_r;
        end else begin
          st_nxt    = (16'(base_b) == 16'(addr_r)) ? bat_pkg::ST_OK
                                                   : bat_pkg::ST_MISMATCH;
          ram_we    = 1'b1;
          ram_waddr = c_r;
          ram_wdata = bat_pkg::NS_FREE;
          ram_re    = 1'b1;
          ram_raddr = c_r ^ NW'(1);
        end
      end
      bat_pkg::S_F_O: begin
        if (rd_st == bat_pkg::NS_FREE) begin
          ram_we    = 1'b1;
          ram_waddr = left_idx;
          ram_wdata = bat_pkg::NS_ABSENT;
        end else begin
          fin        = 1'b1;
          fin_status = st_r;
        end
      end
      bat_pkg::S_F_M1: begin
        ram_we    = 1'b1;
        ram_waddr = right_idx;
        ram_wdata = bat_pkg::NS_ABSENT;
      end
      bat_pkg::S_F_M2: begin
        ram_we     = 1'b1;
        ram_wdata  = bat_pkg::NS_FREE;
        fin        = 1'b1;
        fin_status = st_r;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
    if (cfg_wr) begin
      init_nxt = pwdata[OW-1:0];
      cho_nxt  = cfg_sat;
      clr_nxt  = '0;
    end
  end

  assign out_valid_nxt  = fin && !cfg_wr;
  assign out_addr_nxt   = fin_addr;
  assign out_status_nxt = fin_status;
  assign out_ord_nxt    = cho_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bat_pkg::S_CLEAR;
      init_r      <= bat_pkg::INIT_ORDER_RST;
      cho_r       <= (bat_pkg::INIT_ORDER_RST > OW'(LIM)) ? OW'(LIM)
                                                          : bat_pkg::INIT_ORDER_RST;
      clr_r       <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      cho_r       <= cho_nxt;
      clr_r       <= clr_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    c_r          <= c_nxt;
    k_r          <= k_nxt;
    addr_r       <= addr_nxt;
    st_r         <= st_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_ord_r    <= out_ord_nxt;
    if (state_r == bat_pkg::S_A_INIT) begin
      stack_r[0] <= root_idx;
    end
    if (push) begin
      stack_r[sp_r[IW-1:0]]            <= right_idx;
      stack_r[IW'(sp_r + SPW'(1))]     <= left_idx;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;
  assign out_heap_order     = out_ord_r;

  // A result lasts one cycle, since the sequencer returns to idle.
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK))
    else $error("walk stack overflow");

  a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cho_r <= OW'(LIM))
    else $error("heap order beyond limit");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bat_pkg::S_CLEAR) |-> busy)
    else $error("input accepted during clearing sweep");

  a_fail_only_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bat_pkg::S_A_FAIL) |-> (sp_r == '0))
    else $error("search failed with nodes left on the stack");

endmodule

// ===== hw/rtl/bat_ram.sv =====
module bat_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bat_node.sv =====
// Decodes a heap-style node index into its block order and base address.
module bat_node #(
  parameter int MAX_ORDER = 12
) (
  input  logic [MAX_ORDER:0]                 idx,
  output logic [bat_pkg::ORD_W-1:0]          order,
  output logic [MAX_ORDER-1:0]               base
);

  localparam int NW = MAX_ORDER + 1;

  logic [bat_pkg::ORD_W-1:0] depth;
  logic [NW-1:0]             low_bits;
  logic [NW-1:0]             shifted;

  always_comb begin
    depth = '0;
    for (int b = 0; b < NW; b++) begin
      if (idx[b]) begin
        depth = bat_pkg::ORD_W'(b);
      end
    end
  end

  assign order    = bat_pkg::ORD_W'(MAX_ORDER) - depth;
  assign low_bits = idx & ~(NW'(1) << depth);
  assign shifted  = low_bits << order;
  assign base     = shifted[MAX_ORDER-1:0];

endmodule
